### hw/rtl/rgb565_backlight_pixel_converter_unit_macros.svh
// ---------------------------------------------------------------------------
// RGB565 backlight pixel converter - assertion macros
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef RGB565_BACKLIGHT_PIXEL_CONVERTER_UNIT_MACROS_SVH
`define RGB565_BACKLIGHT_PIXEL_CONVERTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define R565BL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define R565BL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define R565BL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define R565BL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/r565bl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// r565bl_pkg
// Shared types, register indexes and palette constants of the converter.
// ---------------------------------------------------------------------------
package r565bl_pkg;

    localparam int PIXEL_W = 16;
    localparam int CHAN_W  = 8;

    typedef enum logic [1:0] {
        REG_DISPLAY_MODE    = 2'd0,
        REG_BACKLIGHT_LEVEL = 2'd1,
        REG_DISPLAY_ON      = 2'd2,
        REG_LOW_BIT_FILL    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FILL_GREEN_LSB = 2'd0,
        FILL_REPLICATE = 2'd1,
        FILL_ZERO      = 2'd2,
        FILL_ONE       = 2'd3
    } t_fill;

    typedef struct packed {
        logic              display_mode;
        logic [CHAN_W-1:0] backlight_level;
        logic              display_on;
        t_fill             low_bit_fill;
    } t_cfg;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_rgb;

    // blend endpoints: bg + (fg - bg) * (w + 1) / 256
    typedef struct packed {
        t_rgb fg;
        t_rgb bg;
    } t_blend_req;

    localparam t_rgb DIM_PAL [2] = '{
        '{blue: 8'd46, green: 8'd61, red: 8'd57},
        '{blue: 8'd18, green: 8'd27, red: 8'd24}
    };

    localparam t_rgb BRIGHT_PAL [2] = '{
        '{blue: 8'd237, green: 8'd171, red: 8'd154},
        '{blue: 8'd146, green: 8'd35,  red: 8'd37}
    };

endpackage

### hw/rtl/r565bl_expand.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// r565bl_expand
// Widens RGB565 to 8 bits per channel or picks the monochrome palette pair.
// ---------------------------------------------------------------------------
module r565bl_expand
    import r565bl_pkg::*;
(
    input  logic [PIXEL_W-1:0] i_pixel,
    input  t_cfg               i_cfg,
    output t_blend_req         o_req
);

    logic [PIXEL_W-1:0] w_px;
    logic [4:0]         w_r5;
    logic [5:0]         w_g6;
    logic [4:0]         w_b5;
    logic [7:0]         w_rr;
    logic [7:0]         w_gg;
    logic [7:0]         w_bb;
    logic               w_sel;

    assign w_px  = i_cfg.display_on ? i_pixel : '0;
    assign w_r5  = w_px[15:11];
    assign w_g6  = w_px[10:5];
    assign w_b5  = w_px[4:0];
    assign w_sel = w_px[15];

    always_comb begin
        case (i_cfg.low_bit_fill)
            FILL_GREEN_LSB: begin
                w_rr = {w_r5, w_g6[0], w_r5[4:3]};
                w_gg = {w_g6, w_g6[5:4]};
                w_bb = {w_b5, w_g6[0], w_b5[4:3]};
            end
            FILL_REPLICATE: begin
                w_rr = {w_r5, w_r5[4:2]};
                w_gg = {w_g6, w_g6[5:4]};
                w_bb = {w_b5, w_b5[4:2]};
            end
            FILL_ZERO: begin
                w_rr = {w_r5, 1'b0, w_r5[3:2]};
                w_gg = {w_g6, 1'b0, w_g6[4]};
                w_bb = {w_b5, 1'b0, w_b5[3:2]};
            end
            default: begin
                w_rr = {w_r5, 1'b1, w_r5[3:2]};
                w_gg = {w_g6, 1'b1, w_g6[4]};
                w_bb = {w_b5, 1'b1, w_b5[3:2]};
            end
        endcase
    end

    always_comb begin
        if (i_cfg.display_mode) begin
            o_req.fg = BRIGHT_PAL[w_sel];
            o_req.bg = DIM_PAL[w_sel];
        end else begin
            o_req.fg = '{blue: w_bb, green: w_gg, red: w_rr};
            o_req.bg = '0;
        end
    end

endmodule

### hw/rtl/r565bl_blend.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// r565bl_blend
// One channel of the backlight blend: bg + (fg - bg) * (w + 1) / 256.
// ---------------------------------------------------------------------------
module r565bl_blend
    import r565bl_pkg::*;
(
    input  logic [CHAN_W-1:0] i_fg,
    input  logic [CHAN_W-1:0] i_bg,
    input  logic [CHAN_W-1:0] i_weight,
    output logic [CHAN_W-1:0] o_value
);

    logic [CHAN_W-1:0]   w_diff;
    logic [CHAN_W:0]     w_scale;
    logic [2*CHAN_W-1:0] w_prod;

    // fg >= bg always, so the difference never wraps
    assign w_diff  = i_fg - i_bg;
    assign w_scale = {1'b0, i_weight} + {{CHAN_W{1'b0}}, 1'b1};
    // 255 * 256 fits in 16 bits
    assign w_prod  = {{CHAN_W{1'b0}}, w_diff} * {{(CHAN_W-1){1'b0}}, w_scale};
    assign o_value = i_bg + w_prod[2*CHAN_W-1:CHAN_W];

endmodule

### hw/rtl/rgb565_backlight_pixel_converter_unit.sv
`timescale 1ns / 1ps
// Pipeline: an accepted request loads the input reg; the result reg is
//   loaded from it when the output side can advance, and drives m_axis_tvalid.
// Throughput: one pixel per clock while m_axis_tready is not held low;
//   one 8x9 multiply per channel sits between the input register and the result register.
// Reset: synchronous, active low; clears both valid flags and all
//   configuration registers to zero. Payload registers are not reset.
// ---------------------------------------------------------------------------
// rgb565_backlight_pixel_converter_unit
// RGB565 / monochrome pixel to RGB888 with backlight blend, stream in/out.
// ---------------------------------------------------------------------------
`include "rgb565_backlight_pixel_converter_unit_macros.svh"

module rgb565_backlight_pixel_converter_unit
    import r565bl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] pixel
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

    t_cfg               r_cfg;
    logic               r_s1_valid;
    logic [PIXEL_W-1:0] r_s1_pixel;
    logic               r_out_valid;
    t_rgb               r_out;
    logic               w_adv;
    logic               w_s_accept;
    t_blend_req         w_req;
    t_rgb               n_out;

    // output side moves when empty or taken
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv || !r_s1_valid;
    assign w_s_accept    = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    REG_DISPLAY_MODE:    r_cfg.display_mode    <= i_cfg_wdata[0];
                    REG_BACKLIGHT_LEVEL: r_cfg.backlight_level <= i_cfg_wdata;
                    REG_DISPLAY_ON:      r_cfg.display_on      <= i_cfg_wdata[0];
                    REG_LOW_BIT_FILL:    r_cfg.low_bit_fill    <= t_fill'(i_cfg_wdata[1:0]);
                    default:             r_cfg                 <= r_cfg;
                endcase
            end
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_s1_pixel <= s_axis_tdata;
        end
        if (w_adv && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    r565bl_expand u_expand (
        .i_pixel (r_s1_pixel),
        .i_cfg   (r_cfg),
        .o_req   (w_req)
    );

    r565bl_blend u_blend_red (
        .i_fg     (w_req.fg.red),
        .i_bg     (w_req.bg.red),
        .i_weight (r_cfg.backlight_level),
        .o_value  (n_out.red)
    );

    r565bl_blend u_blend_green (
        .i_fg     (w_req.fg.green),
        .i_bg     (w_req.bg.green),
        .i_weight (r_cfg.backlight_level),
        .o_value  (n_out.green)
    );

    r565bl_blend u_blend_blue (
        .i_fg     (w_req.fg.blue),
        .i_bg     (w_req.bg.blue),
        .i_weight (r_cfg.backlight_level),
        .o_value  (n_out.blue)
    );

    // a full input stage that cannot drain keeps its request
    `R565BL_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !w_adv, r_s1_valid)
    // an accepted request always lands in the input stage
    `R565BL_ASSERT_NEXT(a_s1_fill, i_clk, i_rst_n, w_s_accept, r_s1_valid)
    // backpressure only when both stages are occupied
    `R565BL_ASSERT_IMPL(a_busy_full, i_clk, i_rst_n, !s_axis_tready, r_s1_valid && r_out_valid)

endmodule
